// File: rtl/ectc_pkg.sv
package ectc_pkg;

  localparam logic [31:0] SEC_RANGE    = 32'd3155760000;
  localparam logic [25:0] RECIP_675    = 26'd50903317;
  localparam logic [16:0] RECIP_1461   = 17'd91868;
  localparam logic [16:0] RECIP_7      = 17'd74899;
  localparam logic [15:0] RECIP_15_TOD = 16'd34953;
  localparam logic [9:0]  RECIP_15_MIN = 10'd547;
  localparam logic [15:0] DAYS_QUAD    = 16'd1461;
  localparam logic [10:0] YEAR1_START  = 11'd366;
  localparam logic [10:0] YEAR2_START  = 11'd731;
  localparam logic [10:0] YEAR3_START  = 11'd1096;
  localparam logic [11:0] BASE_YEAR    = 12'd2000;
  localparam int unsigned OUT_DATA_W   = 48;

  typedef struct packed {
    logic        ok;
    logic [15:0] days;
    logic [16:0] tod;
    logic [4:0]  quad;
    logic [16:0] dv;
    logic [12:0] wq;
  } day_t;

  typedef struct packed {
    logic        ok;
    logic [5:0]  second;
    logic [4:0]  hour;
    logic [10:0] mt;
    logic [11:0] year;
    logic [8:0]  doy;
    logic        leap;
    logic [2:0]  weekday;
  } tdate_t;

  // first day of month (0-based index) within the year
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    begin
      case (idx)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && idx >= 4'd2) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

// File: rtl/ectc_day_split.sv
module ectc_day_split (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [63:0]      in_secs,
  output logic             out_valid,
  input  logic             out_ready,
  output ectc_pkg::day_t   out_data
);

  logic        v1_r, v2_r, v3_r;
  logic        rdy1, rdy2, rdy3;

  logic        ok1_r;
  logic [31:0] secs1_r;
  logic        ok1_nxt;

  logic        ok2_r;
  logic [15:0] days2_r;
  logic [24:0] x2_r;
  logic [6:0]  low2_r;
  logic [50:0] prod_days;

  ectc_pkg::day_t s3_r;
  ectc_pkg::day_t s3_nxt;
  logic [24:0] prod_675;
  logic [24:0] rem_full;
  logic [32:0] prod_quad;
  logic [16:0] dv;
  logic [33:0] prod_wk;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign ok1_nxt = (in_secs[63:32] == 32'd0) && (in_secs[31:0] < ectc_pkg::SEC_RANGE);

  // days = secs / 86400 = (secs >> 7) / 675
  assign prod_days = {26'd0, secs1_r[31:7]} * {25'd0, ectc_pkg::RECIP_675};

  assign prod_675  = {9'd0, days2_r} * 25'd675;
  assign rem_full  = x2_r - prod_675;
  assign prod_quad = {16'd0, days2_r} * {16'd0, ectc_pkg::RECIP_1461};
  assign dv        = {1'b0, days2_r} + 17'd6;
  assign prod_wk   = {17'd0, dv} * {17'd0, ectc_pkg::RECIP_7};

  always_comb begin
    s3_nxt.ok   = ok2_r;
    s3_nxt.days = days2_r;
    s3_nxt.tod  = {rem_full[9:0], low2_r};
    s3_nxt.quad = prod_quad[31:27];
    s3_nxt.dv   = dv;
    s3_nxt.wq   = prod_wk[31:19];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ok1_r   <= ok1_nxt;
      secs1_r <= in_secs[31:0];
    end
    if (rdy2) begin
      ok2_r   <= ok1_r;
      days2_r <= prod_days[50:35];
      x2_r    <= secs1_r[31:7];
      low2_r  <= secs1_r[6:0];
    end
    if (rdy3) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

// File: rtl/ectc_time_date.sv
module ectc_time_date (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ectc_pkg::day_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ectc_pkg::tdate_t out_data
);

  logic        v4_r, v5_r;
  logic        rdy4, rdy5;

  logic        ok4_r;
  logic [2:0]  wd4_r;
  logic [10:0] d4_r;
  logic [4:0]  quad4_r;
  logic [10:0] mt4_r;
  logic [16:0] tod4_r;

  logic [16:0] prod_w7;
  logic [16:0] wd_full;
  logic [15:0] prod_q;
  logic [15:0] d4_full;
  logic [30:0] prod_mt;

  logic [16:0] prod_s60;
  logic [16:0] sec_full;
  logic [18:0] prod_hr;
  logic [1:0]  yq;
  logic [10:0] yofs;
  logic [10:0] doy_full;

  ectc_pkg::tdate_t s5_r;
  ectc_pkg::tdate_t s5_nxt;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign in_ready = rdy4;

  assign prod_w7 = {4'd0, in_data.wq} * 17'd7;
  assign wd_full = in_data.dv - prod_w7;
  assign prod_q  = {11'd0, in_data.quad} * ectc_pkg::DAYS_QUAD;
  assign d4_full = in_data.days - prod_q;
  // minutes of day = tod / 60 = (tod >> 2) / 15
  assign prod_mt = {16'd0, in_data.tod[16:2]} * {15'd0, ectc_pkg::RECIP_15_TOD};

  assign prod_s60 = {6'd0, mt4_r} * 17'd60;
  assign sec_full = tod4_r - prod_s60;
  assign prod_hr  = {10'd0, mt4_r[10:2]} * {9'd0, ectc_pkg::RECIP_15_MIN};

  // leap year leads each four-year run
  always_comb begin
    if (d4_r < ectc_pkg::YEAR1_START) begin
      yq   = 2'd0;
      yofs = 11'd0;
    end else if (d4_r < ectc_pkg::YEAR2_START) begin
      yq   = 2'd1;
      yofs = ectc_pkg::YEAR1_START;
    end else if (d4_r < ectc_pkg::YEAR3_START) begin
      yq   = 2'd2;
      yofs = ectc_pkg::YEAR2_START;
    end else begin
      yq   = 2'd3;
      yofs = ectc_pkg::YEAR3_START;
    end
  end

  assign doy_full = d4_r - yofs;

  always_comb begin
    s5_nxt.ok      = ok4_r;
    s5_nxt.second  = sec_full[5:0];
    s5_nxt.hour    = prod_hr[17:13];
    s5_nxt.mt      = mt4_r;
    s5_nxt.year    = ectc_pkg::BASE_YEAR + {5'd0, quad4_r, yq};
    s5_nxt.doy     = doy_full[8:0];
    s5_nxt.leap    = (yq == 2'd0);
    s5_nxt.weekday = wd4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      ok4_r   <= in_data.ok;
      wd4_r   <= wd_full[2:0];
      d4_r    <= d4_full[10:0];
      quad4_r <= in_data.quad;
      mt4_r   <= prod_mt[29:19];
      tod4_r  <= in_data.tod;
    end
    if (rdy5) begin
      s5_r <= s5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = s5_r;

endmodule

// File: rtl/epoch_seconds_to_calendar_core.sv
// Seconds-since-2000 to calendar date and time converter.
// Input: in_tvalid/in_tready/in_tdata, one item is a 64-bit unsigned count
// of seconds since 2000-01-01 00:00:00.
// Output: out_tvalid/out_tready/out_tdata/out_tuser, one item per input item,
// in order. out_tuser is 1 when the count lies within years 2000 to 2099;
// otherwise it is 0 and every out_tdata field is 0.
// Throughput: one item per cycle when the output does not stall; six
// register stages, each with its own valid bit, built around reciprocal
// multiplies (by 86400, 1461, 7, 60).
// Stall: when out_tready is low the result holds in the output register and
// empty stages behind it keep filling; in_tready falls only when all six
// stages hold items.
// Reset (rst_n low, synchronous) empties all stages; the block keeps no
// other state.
module epoch_seconds_to_calendar_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [63:0]                       in_tdata,  // elapsed_seconds
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // year, month, day_of_month, weekday, hour, minute, second, zero pad
  output logic [ectc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [0:0]                        out_tuser  // valid_res
);

  logic             a_valid, a_ready;
  ectc_pkg::day_t   a_data;
  logic             b_valid, b_ready;
  ectc_pkg::tdate_t b_data;

  logic        v6_r;
  logic        rdy6;

  logic        ok6_r;
  logic [11:0] year6_r;
  logic [3:0]  month6_r;
  logic [4:0]  dom6_r;
  logic [2:0]  wd6_r;
  logic [4:0]  hour6_r;
  logic [5:0]  min6_r;
  logic [5:0]  sec6_r;

  logic [3:0]  mon_nxt;
  logic [8:0]  mstart;
  logic [8:0]  dom_full;
  logic [10:0] prod_h60;
  logic [10:0] min_full;

  ectc_day_split u_day_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_secs   (in_tdata),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_data  (a_data)
  );

  ectc_time_date u_time_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_data   (a_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  assign rdy6    = !v6_r || out_tready;
  assign b_ready = rdy6;

  always_comb begin
    mon_nxt = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if (b_data.doy >= ectc_pkg::month_start(4'(i), b_data.leap)) begin
        mon_nxt = 4'(i + 1);
      end
    end
  end

  assign mstart   = ectc_pkg::month_start(mon_nxt - 4'd1, b_data.leap);
  assign dom_full = b_data.doy - mstart + 9'd1;
  assign prod_h60 = {6'd0, b_data.hour} * 11'd60;
  assign min_full = b_data.mt - prod_h60;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (rdy6) begin
      v6_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      ok6_r <= b_data.ok;
      if (b_data.ok) begin
        year6_r  <= b_data.year;
        month6_r <= mon_nxt;
        dom6_r   <= dom_full[4:0];
        wd6_r    <= b_data.weekday;
        hour6_r  <= b_data.hour;
        min6_r   <= min_full[5:0];
        sec6_r   <= b_data.second;
      end else begin
        year6_r  <= 12'd0;
        month6_r <= 4'd0;
        dom6_r   <= 5'd0;
        wd6_r    <= 3'd0;
        hour6_r  <= 5'd0;
        min6_r   <= 6'd0;
        sec6_r   <= 6'd0;
      end
    end
  end

  assign out_tvalid = v6_r;
  assign out_tuser  = ok6_r;
  assign out_tdata  = {7'd0, sec6_r, min6_r, hour6_r, wd6_r, dom6_r, month6_r, year6_r};

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ok6_r |-> month6_r != 4'd0 && month6_r <= 4'd12)
    else $error("month out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ok6_r |-> hour6_r < 5'd24 && min6_r < 6'd60 && sec6_r < 6'd60)
    else $error("time of day out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ok6_r |-> dom6_r != 5'd0 && wd6_r < 3'd7 && year6_r < 12'd2100)
    else $error("date field out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !ok6_r |-> out_tdata == '0)
    else $error("out of range item carries non-zero fields");

endmodule
